/* rtl/prffr_pkg.sv */
// Shared constants, command/status types and helpers for the page range reserver.
package prffr_pkg;

  localparam int PAGE_COUNT = 4096;
  localparam int PAGE_AW    = $clog2(PAGE_COUNT);
  localparam int PTR_W      = PAGE_AW + 1;

  localparam int FLAG_W  = 8;
  localparam int PAGE_W  = 12;
  localparam int LEN_W   = 13;
  localparam int BOUND_W = 13;
  localparam int LOG2_W  = 4;
  localparam int SUM_W   = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_MAPPED_MASK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MMAP_BOUND   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_LOG2   = 2'd2;

  localparam logic [FLAG_W-1:0]  RST_MAPPED_MASK = 8'd32;
  localparam logic [BOUND_W-1:0] RST_MMAP_BOUND  = 13'd2048;
  localparam logic [LOG2_W-1:0]  RST_ALIGN_LOG2  = 4'd4;

  localparam logic KIND_RESERVE = 1'b0;
  localparam logic KIND_WRITE   = 1'b1;

  typedef struct packed {
    logic clear;
    logic load;
    logic scan;
    logic fill_load;
    logic fill;
    logic write_one;
    logic finish;
    logic fin_ok;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_end;
    logic scan_ok;
    logic fill_need;
    logic fill_last;
  } status_t;

  function automatic logic [PTR_W-1:0] align_mask(input logic [LOG2_W-1:0] lg);
    logic [PTR_W-1:0] m;
    m = '0;
    for (int i = 0; i < PTR_W; i++) begin
      m[i] = (i < int'(lg));
    end
    return m;
  endfunction

endpackage

/* rtl/prffr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module prffr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/prffr_ctrl.sv */
// Sequencer for clearing, scanning, filling and single-page writes.
module prffr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              kind,
  input  prffr_pkg::status_t status,
  output prffr_pkg::cmd_t    cmd,
  output logic              busy
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_FILL  = 5'b01000,
    ST_WRITE = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = (kind == prffr_pkg::KIND_WRITE) ? ST_WRITE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_end) begin
          if (status.scan_ok && status.fill_need) begin
            cmd.fill_load = 1'b1;
            state_next    = ST_FILL;
          end else begin
            cmd.finish = 1'b1;
            cmd.fin_ok = status.scan_ok;
            state_next = ST_IDLE;
          end
        end
      end
      ST_FILL: begin
        cmd.fill = 1'b1;
        if (status.fill_last) begin
          cmd.finish = 1'b1;
          cmd.fin_ok = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_WRITE: begin
        cmd.write_one = 1'b1;
        cmd.finish    = 1'b1;
        cmd.fin_ok    = 1'b1;
        state_next    = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

/* rtl/prffr_datapath.sv */
// Page flag table, scan pointer, run tracking, config registers and result register.
module prffr_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  prffr_pkg::cmd_t                       cmd,
  output prffr_pkg::status_t                    status,
  input  logic                                  cfg_write,
  input  logic [prffr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [prffr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                  kind,
  input  logic [prffr_pkg::PAGE_W-1:0]          first_page,
  input  logic [prffr_pkg::LEN_W-1:0]           run_length,
  input  logic                                  may_remap,
  input  logic                                  align_native,
  input  logic [prffr_pkg::PAGE_W-1:0]          align_phase,
  input  logic [prffr_pkg::FLAG_W-1:0]          flag_value,
  output logic                                  done,
  output logic                                  success,
  output logic [prffr_pkg::PAGE_W-1:0]          run_start
);

  logic [prffr_pkg::FLAG_W-1:0]  mapped_mask;
  logic [prffr_pkg::BOUND_W-1:0] boundary;
  logic [prffr_pkg::LOG2_W-1:0]  align_log2_q;

  logic                          kind_q;
  logic [prffr_pkg::PAGE_W-1:0]  start_q;
  logic [prffr_pkg::LEN_W-1:0]   len_q;
  logic                          remap_q;
  logic                          align_q;
  logic [prffr_pkg::PAGE_W-1:0]  phase_q;
  logic [prffr_pkg::FLAG_W-1:0]  flag_q;

  logic [prffr_pkg::PTR_W-1:0]   addr;
  logic [prffr_pkg::PTR_W-1:0]   addr_inc;
  logic                          in_run;
  logic                          in_run_next;
  logic [prffr_pkg::LEN_W-1:0]   k;
  logic [prffr_pkg::LEN_W-1:0]   k_next;
  logic [prffr_pkg::PTR_W-1:0]   s_reg;
  logic [prffr_pkg::PTR_W-1:0]   s_cur;
  logic [prffr_pkg::LEN_W-1:0]   rem;

  logic                          ram_we;
  logic [prffr_pkg::PAGE_AW-1:0] ram_waddr;
  logic [prffr_pkg::FLAG_W-1:0]  ram_wdata;
  logic [prffr_pkg::PAGE_AW-1:0] ram_raddr;
  logic [prffr_pkg::FLAG_W-1:0]  ram_rdata;

  logic                          usable;
  logic                          phase_ok;
  logic [prffr_pkg::PTR_W-1:0]   amask;
  logic [prffr_pkg::SUM_W-1:0]   end_sum;
  logic                          stop_fail;
  logic                          found;
  logic                          bound_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      mapped_mask  <= prffr_pkg::RST_MAPPED_MASK;
      boundary     <= prffr_pkg::RST_MMAP_BOUND;
      align_log2_q <= prffr_pkg::RST_ALIGN_LOG2;
    end else if (cfg_write) begin
      unique case (cfg_index)
        prffr_pkg::CFG_MAPPED_MASK: mapped_mask  <= cfg_data[prffr_pkg::FLAG_W-1:0];
        prffr_pkg::CFG_MMAP_BOUND:  boundary     <= cfg_data[prffr_pkg::BOUND_W-1:0];
        prffr_pkg::CFG_ALIGN_LOG2:  align_log2_q <= cfg_data[prffr_pkg::LOG2_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q  <= kind;
      start_q <= first_page;
      len_q   <= run_length;
      remap_q <= may_remap;
      align_q <= align_native;
      phase_q <= align_phase;
      flag_q  <= flag_value;
    end
  end

  assign addr_inc = addr + prffr_pkg::PTR_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      addr   <= '0;
      in_run <= 1'b0;
    end else begin
      if (cmd.load) begin
        addr   <= prffr_pkg::PTR_W'(first_page);
        in_run <= 1'b0;
      end else if (cmd.fill_load) begin
        addr <= s_cur;
      end else if (cmd.clear || cmd.scan || cmd.fill) begin
        addr <= addr_inc;
      end
      if (cmd.scan) begin
        in_run <= in_run_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      k     <= k_next;
      s_reg <= s_cur;
    end
    if (cmd.fill_load) begin
      rem <= len_q;
    end else if (cmd.fill) begin
      rem <= rem - prffr_pkg::LEN_W'(1);
    end
  end

  assign ram_raddr = cmd.load ? prffr_pkg::PAGE_AW'(first_page)
                              : addr_inc[prffr_pkg::PAGE_AW-1:0];
  assign ram_we    = cmd.clear || cmd.fill || cmd.write_one;
  assign ram_waddr = cmd.write_one ? prffr_pkg::PAGE_AW'(start_q)
                                   : addr[prffr_pkg::PAGE_AW-1:0];
  assign ram_wdata = cmd.clear ? '0 : flag_q;

  prffr_ram #(
    .WIDTH (prffr_pkg::FLAG_W),
    .DEPTH (prffr_pkg::PAGE_COUNT)
  ) u_flags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign usable   = (ram_rdata == '0) || (remap_q && ((ram_rdata & mapped_mask) != '0));
  assign amask    = prffr_pkg::align_mask(align_log2_q);
  assign phase_ok = ((addr ^ prffr_pkg::PTR_W'(phase_q)) & amask) == '0;
  assign end_sum  = prffr_pkg::SUM_W'(addr) + prffr_pkg::SUM_W'(len_q);
  assign s_cur    = in_run ? s_reg : addr;

  always_comb begin
    stop_fail   = 1'b0;
    found       = 1'b0;
    in_run_next = in_run;
    k_next      = k;
    if (!in_run) begin
      priority if (addr >= prffr_pkg::PTR_W'(prffr_pkg::PAGE_COUNT)) begin
        stop_fail = 1'b1;
      end else if (align_q && !phase_ok) begin
        in_run_next = 1'b0;
      end else if (end_sum > prffr_pkg::SUM_W'(prffr_pkg::PAGE_COUNT)) begin
        stop_fail = 1'b1;
      end else if (!usable) begin
        in_run_next = 1'b0;
      end else if (len_q <= prffr_pkg::LEN_W'(1)) begin
        found = 1'b1;
      end else begin
        in_run_next = 1'b1;
        k_next      = prffr_pkg::LEN_W'(1);
      end
    end else begin
      priority if (!usable) begin
        in_run_next = 1'b0;
      end else if ((k + prffr_pkg::LEN_W'(1)) == len_q) begin
        found = 1'b1;
      end else begin
        k_next = k + prffr_pkg::LEN_W'(1);
      end
    end
  end

  assign bound_hit = (prffr_pkg::BOUND_W'(start_q) < boundary)
                  && (prffr_pkg::BOUND_W'(s_cur) >= boundary);

  assign status.clear_last = (addr == prffr_pkg::PTR_W'(prffr_pkg::PAGE_COUNT - 1));
  assign status.scan_end   = stop_fail || found;
  assign status.scan_ok    = found && !bound_hit;
  assign status.fill_need  = (len_q != '0);
  assign status.fill_last  = (rem == prffr_pkg::LEN_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      success <= cmd.fin_ok;
      if (cmd.fin_ok && (kind_q == prffr_pkg::KIND_RESERVE)) begin
        run_start <= cmd.scan ? s_cur[prffr_pkg::PAGE_W-1:0]
                              : s_reg[prffr_pkg::PAGE_W-1:0];
      end else begin
        run_start <= '0;
      end
    end
  end

endmodule

/* rtl/page_range_first_fit_reserver_unit.sv */
// Top level of the first-fit contiguous page range reserver.
//
// After reset the unit clears its 4096-entry page flag table, one page per cycle, and
// holds busy high while it does so; configuration writes are taken at any time.
// An item is taken when start is high and busy is low, one item at a time. A write
// item writes flag_value to first_page in the write state that follows, then answers.
// A reserve item walks the flag table one page per cycle from first_page until it
// finds a run or fails; on success with a nonzero run_length it then fills the run
// through the table's single write port before it answers, while a failure or a
// zero-length run answers without a fill. The answer is shown on success and
// run_start for the single cycle in which done is high; the receiver must take it
// then, as nothing holds it.
module page_range_first_fit_reserver_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cfg_write,
  input  logic [prffr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prffr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             kind,
  input  logic [prffr_pkg::PAGE_W-1:0]     first_page,
  input  logic [prffr_pkg::LEN_W-1:0]      run_length,
  input  logic                             may_remap,
  input  logic                             align_native,
  input  logic [prffr_pkg::PAGE_W-1:0]     align_phase,
  input  logic [prffr_pkg::FLAG_W-1:0]     flag_value,
  output logic                             done,
  output logic                             success,
  output logic [prffr_pkg::PAGE_W-1:0]     run_start
);

  prffr_pkg::cmd_t    cmd;
  prffr_pkg::status_t status;

  prffr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (kind),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  prffr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .kind         (kind),
    .first_page   (first_page),
    .run_length   (run_length),
    .may_remap    (may_remap),
    .align_native (align_native),
    .align_phase  (align_phase),
    .flag_value   (flag_value),
    .done         (done),
    .success      (success),
    .run_start    (run_start)
  );

endmodule

/* rtl/prffr_checker.sv */
// Port-level checks on the reserver's command and result beats, bound to the top level.
module prffr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic                         success,
  input logic [prffr_pkg::PAGE_W-1:0] run_start
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted beat");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without preceding work");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beats back to back");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !success) |-> (run_start == '0))
    else $error("failed result carries a nonzero run start");

endmodule

bind page_range_first_fit_reserver_unit prffr_checker u_prffr_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .success   (success),
  .run_start (run_start)
);
